### sv/preemptive_priority_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the preemptive priority scheduler
// Checks sample on aclk; the plain form is disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define PPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("scheduler check failed");
`define PPS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("scheduler check failed");
`else
`define PPS_ASSERT(lbl, prop)
`define PPS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### sv/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the scheduler cells and the top level.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int MAX_SLOTS_DEF = 16;
    localparam int SLOT_IDX_W    = 8;   // holds any cell index up to 256 slots
    localparam int TIME_W        = 20;
    localparam int BURST_W       = 12;
    localparam int PRIO_W        = 8;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic               mode;
        logic [3:0]         slot;
        logic [TIME_W-1:0]  arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } in_t;

    typedef struct packed {
        logic              ran_valid;
        logic [3:0]        ran_slot;
        logic              finished;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } out_t;

    // best candidate so far plus a pending-slot count saturating at two
    typedef struct packed {
        logic                  found;
        logic [SLOT_IDX_W-1:0] slot;
        logic [PRIO_W-1:0]     prio;
        logic [TIME_W-1:0]     arrival;
        logic [BURST_W-1:0]    burst;
        logic [BURST_W-1:0]    rem;
        logic [1:0]            pend;
    } cand_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic                  load_en;
        logic [SLOT_IDX_W-1:0] load_slot;
        logic [TIME_W-1:0]     arrival;
        logic [BURST_W-1:0]    burst;
        logic [PRIO_W-1:0]     prio;
        logic                  dec_en;
        logic [SLOT_IDX_W-1:0] dec_slot;
    } ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_TAT,
        ST_OUT
    } state_t;

endpackage

### sv/pps_cell.sv
// ----------------------------------------------------------------------------
// pps_cell
// One process slot: holds its fields and remaining work, and merges itself
// into the candidate handed along the chain, one hop per cycle.
// ----------------------------------------------------------------------------
module pps_cell #(
    parameter int IDX = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pps_pkg::ctl_t                ctl,
    input  logic [pps_pkg::TIME_W-1:0]   now,
    input  pps_pkg::cand_t               cand_in,
    output pps_pkg::cand_t               cand_out
);

    localparam logic [pps_pkg::SLOT_IDX_W-1:0] MY_IDX = pps_pkg::SLOT_IDX_W'(IDX);

    logic [pps_pkg::TIME_W-1:0]  arr_reg;
    logic [pps_pkg::BURST_W-1:0] bur_reg;
    logic [pps_pkg::PRIO_W-1:0]  pri_reg;
    logic [pps_pkg::BURST_W-1:0] rem_reg;
    pps_pkg::cand_t              cand_reg, cand_next;

    logic pending, eligible, better;

    always_comb begin
        pending  = (rem_reg != '0);
        eligible = pending && (arr_reg <= now);
        // strict compares keep the earlier slot on a full tie
        better   = eligible && (!cand_in.found || (pri_reg < cand_in.prio) ||
                   ((pri_reg == cand_in.prio) && (arr_reg < cand_in.arrival)));
        if (better) begin
            cand_next.found   = 1'b1;
            cand_next.slot    = MY_IDX;
            cand_next.prio    = pri_reg;
            cand_next.arrival = arr_reg;
            cand_next.burst   = bur_reg;
            cand_next.rem     = rem_reg;
        end else begin
            cand_next = cand_in;
        end
        if (cand_in.pend == 2'd2) begin
            cand_next.pend = 2'd2;
        end else begin
            cand_next.pend = cand_in.pend + {1'b0, pending};
        end
    end

    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        if (ctl.load_en && (ctl.load_slot == MY_IDX)) begin
            arr_reg <= ctl.arrival;
            bur_reg <= ctl.burst;
            pri_reg <= ctl.prio;
        end
        if (!aresetn) begin
            rem_reg <= '0;
        end else if (ctl.load_en && (ctl.load_slot == MY_IDX)) begin
            rem_reg <= ctl.burst;
        end else if (ctl.dec_en && (ctl.dec_slot == MY_IDX)) begin
            rem_reg <= rem_reg - 1'b1;
        end
    end

    assign cand_out = cand_reg;

endmodule

### sv/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler over a row of process-slot cells.
// ----------------------------------------------------------------------------
// Input beats (s_valid/s_ready, s_data) either load a slot (mode 0) or run
// one time tick (mode 1). Every input beat gives exactly one result beat on
// m_valid/m_ready, m_data: the slot that ran, completion statistics when it
// finished, and whether any work is still pending.
// Each beat is handled alone: the candidate winner walks the cell chain one
// slot per cycle in the SCAN state, then CALC, TAT and OUT write the result
// register; a new beat is accepted once the block is back in IDLE after that
// write. The length of the scan follows the number of cells in the chain.
// Reset (aresetn low, synchronous) clears all remaining work and time to
// zero; no result is pending afterwards.
// A result waits in the output register while m_ready is low; the next input
// beat is still accepted and worked on, and only its final write to the
// output register waits for the earlier result to leave.
// ----------------------------------------------------------------------------
`include "preemptive_priority_scheduler_macros.svh"

module preemptive_priority_scheduler #(
    parameter int MAX_SLOTS = pps_pkg::MAX_SLOTS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pps_pkg::in_t    s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output pps_pkg::out_t   m_data
);

    localparam int CNT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SLOTS - 1);

    pps_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic mode_reg, mode_next;
    logic [pps_pkg::TIME_W-1:0] now_reg, now_next;
    logic ran_reg, ran_next;
    logic [3:0] slot_reg, slot_next;
    logic fin_reg, fin_next;
    logic done_reg, done_next;
    logic [pps_pkg::TIME_W-1:0] comp_reg, comp_next;
    logic [pps_pkg::TIME_W-1:0] arr_reg, arr_next;
    logic [pps_pkg::BURST_W-1:0] bur_reg, bur_next;
    logic [pps_pkg::TIME_W-1:0] tat_reg, tat_next;
    logic m_valid_reg, m_valid_next;
    pps_pkg::out_t m_data_reg, m_data_next;

    pps_pkg::ctl_t ctl;
    pps_pkg::cand_t chain [MAX_SLOTS+1];
    pps_pkg::cand_t tail;
    logic [pps_pkg::TIME_W-1:0] tat_ext_burst;

    assign chain[0] = '0;
    assign tail     = chain[MAX_SLOTS];

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        pps_cell #(.IDX(g)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .now      (now_reg),
            .cand_in  (chain[g]),
            .cand_out (chain[g+1])
        );
    end

    assign s_ready = (state_reg == pps_pkg::ST_IDLE);

    always_comb begin
        ctl           = '0;
        ctl.load_en   = s_valid && s_ready && !s_data.mode;
        ctl.load_slot = pps_pkg::SLOT_IDX_W'(s_data.slot);
        ctl.arrival   = s_data.arrival;
        ctl.burst     = s_data.burst;
        ctl.prio      = s_data.prio;
        ctl.dec_en    = (state_reg == pps_pkg::ST_CALC) && mode_reg && tail.found;
        ctl.dec_slot  = tail.slot;
    end

    assign tat_ext_burst = pps_pkg::TIME_W'(bur_reg);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        mode_next    = mode_reg;
        now_next     = now_reg;
        ran_next     = ran_reg;
        slot_next    = slot_reg;
        fin_next     = fin_reg;
        done_next    = done_reg;
        comp_next    = comp_reg;
        arr_next     = arr_reg;
        bur_next     = bur_reg;
        tat_next     = tat_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            pps_pkg::ST_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_data.mode;
                    cnt_next   = '0;
                    state_next = pps_pkg::ST_SCAN;
                end
            end
            pps_pkg::ST_SCAN: begin
                // wait until the candidate has crossed every cell
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = pps_pkg::ST_CALC;
                end
            end
            pps_pkg::ST_CALC: begin
                if (mode_reg) begin
                    ran_next  = tail.found;
                    slot_next = tail.slot[3:0];
                    fin_next  = tail.found && (tail.rem == pps_pkg::BURST_W'(1));
                    done_next = (tail.pend == 2'd0) ||
                                ((tail.pend == 2'd1) && tail.found &&
                                 (tail.rem == pps_pkg::BURST_W'(1)));
                    comp_next = (now_reg == pps_pkg::TIME_MAX) ? pps_pkg::TIME_MAX
                                                               : now_reg + 1'b1;
                    if (now_reg != pps_pkg::TIME_MAX) begin
                        now_next = now_reg + 1'b1;
                    end
                end else begin
                    ran_next  = 1'b0;
                    slot_next = '0;
                    fin_next  = 1'b0;
                    done_next = (tail.pend == 2'd0);
                    comp_next = '0;
                end
                arr_next   = tail.arrival;
                bur_next   = tail.burst;
                state_next = pps_pkg::ST_TAT;
            end
            pps_pkg::ST_TAT: begin
                tat_next   = comp_reg - arr_reg;
                state_next = pps_pkg::ST_OUT;
            end
            pps_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.ran_valid       = ran_reg;
                    m_data_next.ran_slot        = ran_reg ? slot_reg : 4'd0;
                    m_data_next.finished        = fin_reg;
                    m_data_next.completion_time = fin_reg ? comp_reg : '0;
                    m_data_next.turnaround      = fin_reg ? tat_reg : '0;
                    // negative waiting only arises once time has saturated
                    m_data_next.waiting         = (fin_reg && (tat_reg >= tat_ext_burst))
                                                  ? tat_reg - tat_ext_burst : '0;
                    m_data_next.all_done        = done_reg;
                    state_next                  = pps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pps_pkg::ST_IDLE;
            now_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            now_reg     <= now_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg    <= cnt_next;
        mode_reg   <= mode_next;
        ran_reg    <= ran_next;
        slot_reg   <= slot_next;
        fin_reg    <= fin_next;
        done_reg   <= done_next;
        comp_reg   <= comp_next;
        arr_reg    <= arr_next;
        bur_reg    <= bur_next;
        tat_reg    <= tat_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PPS_ASSERT(a_now_monotonic, $past(aresetn) |-> now_reg >= $past(now_reg))
    `PPS_ASSERT(a_accept_starts_scan, (s_valid && s_ready) |=> state_reg == pps_pkg::ST_SCAN)
    `PPS_ASSERT(a_finish_has_slot, (m_valid && m_data.finished) |-> m_data.ran_valid)
    `PPS_ASSERT(a_dec_only_tick, ctl.dec_en |-> (mode_reg && !ctl.load_en))

endmodule

### tb/preemptive_priority_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_test
// Self-checking bench for the priority scheduler. Each input beat is run
// through a local scheduling predictor as it is accepted, and every result
// beat is compared field by field against the oldest prediction. Directed
// cases cover idle ticks, zero bursts, reloads and tie-breaks; the random
// part runs job batches until the slots drain, under varied flow control.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_test;

    localparam int SLOTS = pps_pkg::MAX_SLOTS_DEF;
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    logic           aclk;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    pps_pkg::in_t   s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    pps_pkg::out_t  m_data;

    preemptive_priority_scheduler uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // predicted scheduler state
    logic [pps_pkg::TIME_W-1:0]  job_arrival [SLOTS];
    logic [pps_pkg::BURST_W-1:0] job_burst   [SLOTS];
    logic [pps_pkg::PRIO_W-1:0]  job_prio    [SLOTS];
    logic [pps_pkg::BURST_W-1:0] job_left    [SLOTS];
    logic [pps_pkg::TIME_W-1:0]  sched_now;

    pps_pkg::out_t pending_results [$];
    pps_pkg::out_t want_result;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;
    int beats_checked  = 0;
    int completions    = 0;
    int idle_ticks     = 0;
    int mismatches     = 0;

    initial begin
        for (int k = 0; k < SLOTS; k++) begin
            job_arrival[k] = '0;
            job_burst[k]   = '0;
            job_prio[k]    = '0;
            job_left[k]    = '0;
        end
        sched_now = '0;
    end

    function automatic logic work_pending();
        for (int k = 0; k < SLOTS; k++)
            if (job_left[k] != '0)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic pps_pkg::out_t schedule_step(pps_pkg::in_t item);
        pps_pkg::out_t               res;
        logic                        found;
        int                          best;
        logic [pps_pkg::TIME_W-1:0]  comp;
        logic [pps_pkg::TIME_W-1:0]  tat;
        begin
            res   = '0;
            found = 1'b0;
            best  = 0;
            if (item.mode == MODE_LOAD) begin
                job_arrival[item.slot] = item.arrival;
                job_burst[item.slot]   = item.burst;
                job_prio[item.slot]    = item.prio;
                job_left[item.slot]    = item.burst;
            end else begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (job_left[k] == '0 || job_arrival[k] > sched_now)
                        continue;
                    if (!found) begin
                        found = 1'b1;
                        best  = k;
                    end else if (job_prio[k] < job_prio[best] ||
                                 (job_prio[k] == job_prio[best] &&
                                  job_arrival[k] < job_arrival[best])) begin
                        best = k;
                    end
                end
                if (found) begin
                    job_left[best] = job_left[best] - 1'b1;
                    res.ran_valid  = 1'b1;
                    res.ran_slot   = best[3:0];
                    if (job_left[best] == '0) begin
                        comp = (sched_now == pps_pkg::TIME_MAX) ? pps_pkg::TIME_MAX
                                                                : sched_now + 1'b1;
                        tat  = comp - job_arrival[best];
                        res.finished        = 1'b1;
                        res.completion_time = comp;
                        res.turnaround      = tat;
                        // only negative once time has saturated
                        res.waiting = (tat >= pps_pkg::TIME_W'(job_burst[best])) ?
                                      tat - pps_pkg::TIME_W'(job_burst[best]) : '0;
                    end
                end
                if (sched_now != pps_pkg::TIME_MAX)
                    sched_now = sched_now + 1'b1;
            end
            res.all_done = !work_pending();
            return res;
        end
    endfunction

    function automatic pps_pkg::in_t make_load(logic [3:0] slot_idx,
                                               logic [pps_pkg::TIME_W-1:0] arr,
                                               logic [pps_pkg::BURST_W-1:0] work,
                                               logic [pps_pkg::PRIO_W-1:0] level);
        pps_pkg::in_t item;
        begin
            item.mode    = MODE_LOAD;
            item.slot    = slot_idx;
            item.arrival = arr;
            item.burst   = work;
            item.prio    = level;
            return item;
        end
    endfunction

    // tick with random content in the fields the block ignores
    function automatic pps_pkg::in_t make_tick();
        logic [63:0]  raw;
        pps_pkg::in_t item;
        begin
            raw       = {$urandom(), $urandom()};
            item      = raw[$bits(pps_pkg::in_t)-1:0];
            item.mode = MODE_TICK;
            return item;
        end
    endfunction

    // job arriving mostly near the current time, mostly with a small burst and a narrow priority spread
    function automatic pps_pkg::in_t random_job();
        int unsigned                 now_i;
        int unsigned                 lo;
        int unsigned                 pick;
        logic [pps_pkg::TIME_W-1:0]  arr;
        logic [pps_pkg::BURST_W-1:0] work;
        logic [pps_pkg::PRIO_W-1:0]  level;
        begin
            now_i = sched_now;
            lo    = (now_i > 8) ? now_i - 8 : 0;
            pick  = $urandom_range(0, 99);
            if (pick < 3)
                arr = pps_pkg::TIME_W'($urandom());
            else
                arr = pps_pkg::TIME_W'($urandom_range(lo, now_i + 3));
            pick = $urandom_range(0, 99);
            if (pick < 6)
                work = '0;
            else if (pick < 9)
                work = pps_pkg::BURST_W'($urandom());
            else
                work = pps_pkg::BURST_W'($urandom_range(1, 6));
            if ($urandom_range(0, 99) < 60)
                level = pps_pkg::PRIO_W'($urandom_range(0, 3));
            else
                level = pps_pkg::PRIO_W'($urandom_range(0, 255));
            return make_load(4'($urandom()), arr, work, level);
        end
    endfunction

    // holds valid until the beat is taken, then records its prediction
    task automatic send_item(pps_pkg::in_t item);
        pps_pkg::out_t res;
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        res = schedule_step(item);
        pending_results.push_back(res);
        if (item.mode == MODE_TICK && !res.ran_valid)
            idle_ticks++;
        beats_sent++;
    endtask

    task automatic check_field(string name, logic [pps_pkg::TIME_W-1:0] want,
                               logic [pps_pkg::TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with no prediction outstanding");
                mismatches++;
            end else begin
                want_result = pending_results.pop_front();
                check_field("ran_valid", want_result.ran_valid, m_data.ran_valid);
                check_field("ran_slot", want_result.ran_slot, m_data.ran_slot);
                check_field("finished", want_result.finished, m_data.finished);
                check_field("completion_time", want_result.completion_time,
                            m_data.completion_time);
                check_field("turnaround", want_result.turnaround, m_data.turnaround);
                check_field("waiting", want_result.waiting, m_data.waiting);
                check_field("all_done", want_result.all_done, m_data.all_done);
                beats_checked++;
                if (want_result.finished)
                    completions++;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic test_idle_and_extremes();
        pps_pkg::in_t ones;
        begin
            ones = '1;
            send_item(ones);                                    // idle tick from reset
            send_item(make_load(4'hf, pps_pkg::TIME_MAX, '1, '1)); // never arrives
            send_item(make_load(4'h0, '0, '0, '0));             // zero burst
            send_item(make_tick());                             // still idle
            send_item(make_load(4'hf, '0, '0, '1));             // reload cancels work
        end
    endtask

    task automatic test_tie_breaks();
        send_item(make_load(4'd3, 20'd0, 12'd2, 8'd5));
        send_item(make_load(4'd1, 20'd1, 12'd1, 8'd5));
        send_item(make_load(4'd2, 20'd0, 12'd1, 8'd5));
        repeat (4) send_item(make_tick());
    endtask

    task automatic test_preempt_and_reload();
        send_item(make_load(4'd4, sched_now, 12'd3, 8'd9));
        send_item(make_tick());
        send_item(make_load(4'd9, sched_now, 12'd1, 8'd1));     // more urgent arrival
        send_item(make_tick());
        send_item(make_tick());
        send_item(make_load(4'd4, sched_now, 12'd2, 8'd200));   // reload while running
        send_item(make_load(4'd6, sched_now + 1'b1, 12'd1, 8'd0));
        repeat (4) send_item(make_tick());
    endtask

    task automatic test_random_workload(int n_items, int gap_pct, int stall_pct);
        int start;
        int n_jobs;
        int ticks;
        begin
            send_gap_pct   = gap_pct;
            recv_stall_pct = stall_pct;
            start = beats_sent;
            while (beats_sent - start < n_items) begin
                if ($urandom_range(0, 99) < 85) begin
                    n_jobs = $urandom_range(1, 4);
                    repeat (n_jobs) send_item(random_job());
                    ticks = 0;
                    while (work_pending() && ticks < 32) begin
                        if ($urandom_range(0, 99) < 12) begin
                            send_item(random_job());
                        end else begin
                            send_item(make_tick());
                            ticks++;
                        end
                    end
                    // cancel whatever is stuck (long bursts, far arrivals)
                    for (int k = 0; k < SLOTS; k++)
                        if (job_left[k] != '0)
                            send_item(make_load(4'(k), job_arrival[k], '0, job_prio[k]));
                end else begin
                    send_item(pps_pkg::in_t'({$urandom(), $urandom()}));
                end
            end
        end
    endtask

    initial begin
        int drain_cycles;
        drain_cycles = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_and_extremes();
        test_tie_breaks();
        test_preempt_and_reload();
        test_random_workload(430, 19, 63);
        test_random_workload(430, 63, 19);
        test_random_workload(430, 0, 0);
        s_valid <= 1'b0;

        while (pending_results.size() != 0 && drain_cycles < 20000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        if (pending_results.size() != 0) begin
            $display("preemptive_priority_scheduler_test: errors");
            $finish;
        end else begin
            repeat (40) @(posedge aclk);
            $display("ran %0d beats (loads and ticks) through %0d checked results,",
                     beats_sent, beats_checked);
            $display("with %0d job completions and %0d idle ticks", completions, idle_ticks);
            if (mismatches == 0)
                $display("preemptive_priority_scheduler_test: clean");
            else
                $display("preemptive_priority_scheduler_test: errors");
            $finish;
        end
    end

    initial begin
        #5_000_000;
        $display("preemptive_priority_scheduler_test: errors");
        $finish;
    end

endmodule

### filelist.f
+incdir+sv
sv/pps_pkg.sv
sv/pps_cell.sv
sv/preemptive_priority_scheduler.sv
tb/preemptive_priority_scheduler_test.sv
